@@ hdl/sjf_pkg.sv @@
// shared constants, widths and types for the shortest-job-first wait block
// no dependencies; every other file of the block depends on this package
package sjf_pkg;

  // batch capacity and used width of a burst time
  localparam int MAX_JOBS  = 64;
  localparam int TIME_BITS = 16;

  // fixed field widths of the channels
  localparam int BURST_W     = 16;
  localparam int AVG_W       = 21;
  localparam int TOTAL_W     = 27;
  localparam int JOB_TOTAL_W = 7;

  // derived internal widths
  localparam int JOB_W     = (TIME_BITS < BURST_W) ? TIME_BITS : BURST_W;
  localparam int ADDR_W    = $clog2(MAX_JOBS);
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int ELAPSED_W = JOB_W + CNT_W - 1;
  localparam int SUM_W     = ELAPSED_W + CNT_W - 1;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // divider handshake
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/sjf_if.sv @@
// channel interfaces: job items in, result items out
// depends on sjf_pkg for the field widths
interface sjf_job_if;
  logic                          valid;
  logic                          ready;
  logic [sjf_pkg::BURST_W-1:0]   burst_time;
  logic                          last_job;

  modport source (output valid, output burst_time, output last_job, input ready);
  modport sink   (input valid, input burst_time, input last_job, output ready);
endinterface

interface sjf_result_if;
  logic                             valid;
  logic                             ready;
  logic [sjf_pkg::AVG_W-1:0]        average_wait;
  logic [sjf_pkg::TOTAL_W-1:0]      wait_total;
  logic [sjf_pkg::JOB_TOTAL_W-1:0]  job_total;
  logic                             overflowed;

  modport source (output valid, output average_wait, output wait_total,
                  output job_total, output overflowed, input ready);
  modport sink   (input valid, input average_wait, input wait_total,
                  input job_total, input overflowed, output ready);
endinterface

@@ hdl/sjf_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on sjf_pkg for widths and the request/status structs
module sjf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sjf_pkg::div_req_t         req,
  input  logic [sjf_pkg::SUM_W-1:0] dividend,
  input  logic [sjf_pkg::CNT_W-1:0] divisor,
  output sjf_pkg::div_stat_t        stat,
  output logic [sjf_pkg::SUM_W-1:0] quotient
);
  import sjf_pkg::*;

  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;

  // one shift-subtract step
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = DIV_CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (!busy_r && req.start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ hdl/sjf_average_wait_top.sv @@
// shortest-job-first average wait: insertion-sorted job store, final walk, divider
// sequencing: a stored job item passes ST_INS then ST_CMP per entry it moves past, ending in
//   ST_INS or ST_CMP, as the single store read port is registered; a dropped one is not stored;
//   a last item then walks the store (ST_RD, ST_ACC per stored job) and waits for the divide
// throughput: one item at a time; ready only between items
// reset: rst_n synchronous, active low; empties the batch, job store is not cleared
module sjf_average_wait_top (
  input logic          clk,
  input logic          rst_n,
  sjf_job_if.sink      in_job,
  sjf_result_if.source out_res
);
  import sjf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INS  = 7'b0000010,
    ST_CMP  = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 dropped_r, dropped_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [JOB_W-1:0]     burst_r;
  logic                 last_r;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;

  // job store
  logic [JOB_W-1:0]  mem [MAX_JOBS];
  logic [JOB_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [JOB_W-1:0]  wr_data;
  logic              wr_en;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]       avg_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [JOB_TOTAL_W-1:0] jobs_r;
  logic                   ovf_r;
  logic                   out_load;

  // divider
  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [SUM_W-1:0] quotient;

  logic in_fire;
  logic out_fire;

  assign in_job.ready = (state_r == ST_IDLE);
  assign in_fire      = in_job.valid && in_job.ready;
  assign out_fire     = out_valid_r && out_res.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    elapsed_nxt   = elapsed_r;
    sum_nxt       = sum_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r[ADDR_W-1:0];
    wr_data       = burst_r;
    div_req.start = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (count_r == CNT_W'(MAX_JOBS)) begin
            dropped_nxt = 1'b1;
            if (in_job.last_job) begin
              idx_nxt     = '0;
              elapsed_nxt = '0;
              sum_nxt     = '0;
              state_nxt   = ST_RD;
            end
          end else begin
            pos_nxt   = count_r;
            state_nxt = ST_INS;
          end
        end
      end
      // shift larger entries up, one per pass through ST_INS and ST_CMP
      ST_INS: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          idx_nxt     = '0;
          elapsed_nxt = '0;
          sum_nxt     = '0;
          state_nxt = last_r ? ST_RD : ST_IDLE;
        end else begin
          rd_addr   = ADDR_W'(pos_r - 1'b1);
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        wr_en = 1'b1;
        if (rd_data_r > burst_r) begin
          wr_data   = rd_data_r;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = ST_INS;
        end else begin
          count_nxt   = count_r + 1'b1;
          idx_nxt     = '0;
          elapsed_nxt = '0;
          sum_nxt     = '0;
          state_nxt   = last_r ? ST_RD : ST_IDLE;
        end
      end
      // walk the store in ascending order
      ST_RD: begin
        rd_addr = idx_r[ADDR_W-1:0];
        if (idx_r == count_r) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_nxt     = sum_r + SUM_W'(elapsed_r);
        elapsed_nxt = elapsed_r + ELAPSED_W'(rd_data_r);
        idx_nxt     = idx_r + 1'b1;
        state_nxt   = ST_RD;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      // hand the result over once the output register is free
      ST_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_load    = 1'b1;
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          elapsed_nxt = '0;
          sum_nxt     = '0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    sum_r     <= sum_nxt;
    if (in_fire) begin
      burst_r <= in_job.burst_time[JOB_W-1:0];
      last_r  <= in_job.last_job;
    end
    if (out_load) begin
      avg_r   <= AVG_W'(quotient);
      total_r <= TOTAL_W'(sum_r);
      jobs_r  <= JOB_TOTAL_W'(count_r);
      ovf_r   <= dropped_r;
    end
  end

  // job store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  sjf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sum_r),
    .divisor  (count_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign out_res.valid        = out_valid_r;
  assign out_res.average_wait = avg_r;
  assign out_res.wait_total   = total_r;
  assign out_res.job_total    = jobs_r;
  assign out_res.overflowed   = ovf_r;

`ifndef SYNTHESIS
  // the store never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_JOBS))
    else $error("job count above capacity");

  // a division is only started with a nonzero job count
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (count_r != '0))
    else $error("division started on an empty batch");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider done outside the divide step");

  // a loaded result always carries at least one job
  a_out_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && jobs_r != '0))
    else $error("result item with no jobs");
`endif

endmodule
